[design/dtps_pkg.sv]
package dtps_pkg;

    // command codes carried in s_tuser
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_PUT   = 2'd1;
    localparam logic [1:0] CMD_GET   = 2'd2;

    // field widths
    localparam int CMD_W   = 2;
    localparam int CFG_W   = 9;
    localparam int COORD_W = 16;
    localparam int CIN_W   = 16;
    localparam int COL_W   = 12;
    localparam int ALPHA_W = 16;
    localparam int DEPTH_W = 32;
    localparam int CWORD_W = 3 * COL_W + ALPHA_W;

    // clear values
    localparam logic [COL_W-1:0]   COLOR_MAX   = 12'd4095;
    localparam logic [COL_W-1:0]   CLEAR_RED   = 12'd2055;
    localparam logic [COL_W-1:0]   CLEAR_GREEN = 12'd1798;
    localparam logic [COL_W-1:0]   CLEAR_BLUE  = 12'd1541;
    localparam logic [ALPHA_W-1:0] CLEAR_ALPHA = 16'd1;
    localparam logic [DEPTH_W-1:0] DEPTH_FAR   = 32'h7FFF_FFFF;

    // reset value of both screen size registers
    localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // stored color word, red in the lowest bits
    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic [COL_W-1:0]   blue;
        logic [COL_W-1:0]   green;
        logic [COL_W-1:0]   red;
    } color_word_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_CLEAR = 3'b100
    } state_t;

    // signed intensity clamped into 0..4095
    function automatic logic [COL_W-1:0] clamp_color(input logic [CIN_W-1:0] v);
        logic [COL_W-1:0] r;
        if (v[CIN_W-1])
            r = '0;
        else if (v > CIN_W'(COLOR_MAX))
            r = COLOR_MAX;
        else
            r = v[COL_W-1:0];
        return r;
    endfunction

endpackage

[design/depth_tested_pixel_store.sv]
// channel    dir  handshake            payload
// s_axis     in   s_tvalid / s_tready  s_tuser cmd, s_tdata pixel command
// m_axis     out  m_tvalid / m_tready  m_tdata pixel read back by a get
// cfg        in   cfg_we               cfg_index, cfg_data screen size
//
// on a put or a get, accept issues the memory read, the next
// cycle does the depth compare and write, or loads the output register
// a clear is the accept, then a sweep over the screen, one pixel
// written per cycle
// the frame memories have no reset; software must clear before any read, the block does not enforce this
// a get waits in ST_EXEC while the output register is still full
module depth_tested_pixel_store #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration write port
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [dtps_pkg::CFG_W-1:0] cfg_data,
    // command stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [1:0]                s_tuser,  // cmd
    // pos_x, pos_y, red_in, green_in, blue_in, alpha_in, depth_in
    input  logic [127:0]              s_tdata,
    // result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // red_out, green_out, blue_out, alpha_out, depth_out, zero pad
    output logic [87:0]               m_tdata
);

    import dtps_pkg::*;

    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW    = (CFG_W > XW + 1) ? CFG_W : XW + 1;
    localparam int HW    = (CFG_W > YW + 1) ? CFG_W : YW + 1;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] width_reg, height_reg;
    logic [WW-1:0]    w_cfg, w_lim;
    logic [HW-1:0]    h_cfg, h_lim;
    logic [XW-1:0]    x_last, x_in;
    logic [YW-1:0]    y_last, y_in;
    logic [AW-1:0]    addr_in;

    logic             accept;
    logic [1:0]       cmd_reg;
    logic [AW-1:0]    addr_reg;
    color_word_t      color_reg;
    logic [DEPTH_W-1:0] depth_reg;

    logic [XW-1:0]    cx_reg, cx_last_reg;
    logic [YW-1:0]    cy_reg, cy_last_reg;
    logic [AW-1:0]    clr_addr;

    logic             mem_re, mem_we, put_we, out_free, out_load;
    logic [AW-1:0]    mem_waddr;
    color_word_t      color_wdata, color_rdata;
    logic [DEPTH_W-1:0] depth_wdata, depth_rdata;

    logic             m_tvalid_reg;
    color_word_t      out_color_reg;
    logic [DEPTH_W-1:0] out_depth_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_RESET;
            height_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_WIDTH)
                width_reg <= cfg_data;
            else
                height_reg <= cfg_data;
        end
    end

    // screen size limited to 1..max, kept as last coordinate
    always_comb
    begin
        w_cfg = WW'(width_reg);
        h_cfg = HW'(height_reg);
        if (w_cfg == '0)
            w_lim = WW'(1);
        else if (w_cfg > WW'(MAX_WIDTH))
            w_lim = WW'(MAX_WIDTH);
        else
            w_lim = w_cfg;
        if (h_cfg == '0)
            h_lim = HW'(1);
        else if (h_cfg > HW'(MAX_HEIGHT))
            h_lim = HW'(MAX_HEIGHT);
        else
            h_lim = h_cfg;
        x_last = XW'(w_lim - WW'(1));
        y_last = YW'(h_lim - HW'(1));
    end

    // coordinate clamp and pixel address of the incoming command
    always_comb
    begin
        if (s_tdata[COORD_W-1])
            x_in = '0;
        else if (s_tdata[COORD_W-1:0] > COORD_W'(x_last))
            x_in = x_last;
        else
            x_in = XW'(s_tdata[COORD_W-1:0]);
        if (s_tdata[2*COORD_W-1])
            y_in = '0;
        else if (s_tdata[2*COORD_W-1:COORD_W] > COORD_W'(y_last))
            y_in = y_last;
        else
            y_in = YW'(s_tdata[2*COORD_W-1:COORD_W]);
        addr_in = AW'(AW'(y_in) * AW'(MAX_WIDTH) + AW'(x_in));
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign mem_re   = accept && ((s_tuser == CMD_PUT) || (s_tuser == CMD_GET));

    // output register may be reloaded once the held transaction leaves
    assign out_free = !m_tvalid_reg || m_tready;
    assign put_we   = (state_reg == ST_EXEC) && (cmd_reg == CMD_PUT)
                      && ($signed(depth_reg) < $signed(depth_rdata));
    assign out_load = (state_reg == ST_EXEC) && (cmd_reg == CMD_GET) && out_free;

    // controller
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == CMD_CLEAR)
                        state_next = ST_CLEAR;
                    else if (mem_re)
                        state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd_reg != CMD_GET || out_free)
                    state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                if (cx_reg == cx_last_reg && cy_reg == cy_last_reg)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cx_reg    <= '0;
            cy_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // clear sweep, row by row
            if (accept)
            begin
                cx_reg <= '0;
                cy_reg <= '0;
            end
            else if (state_reg == ST_CLEAR)
            begin
                if (cx_reg == cx_last_reg)
                begin
                    cx_reg <= '0;
                    cy_reg <= cy_reg + YW'(1);
                end
                else
                    cx_reg <= cx_reg + XW'(1);
            end
        end
    end

    // payload of the accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg           <= s_tuser;
            addr_reg          <= addr_in;
            cx_last_reg       <= x_last;
            cy_last_reg       <= y_last;
            color_reg.red     <= clamp_color(s_tdata[3*CIN_W-1:2*CIN_W]);
            color_reg.green   <= clamp_color(s_tdata[4*CIN_W-1:3*CIN_W]);
            color_reg.blue    <= clamp_color(s_tdata[5*CIN_W-1:4*CIN_W]);
            color_reg.alpha   <= s_tdata[6*CIN_W-1:5*CIN_W];
            depth_reg         <= s_tdata[6*CIN_W+DEPTH_W-1:6*CIN_W];
        end
    end

    // write port: clear sweep or a put that passes the depth test
    assign clr_addr = AW'(AW'(cy_reg) * AW'(MAX_WIDTH) + AW'(cx_reg));

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we            = 1'b1;
            mem_waddr         = clr_addr;
            color_wdata.red   = CLEAR_RED;
            color_wdata.green = CLEAR_GREEN;
            color_wdata.blue  = CLEAR_BLUE;
            color_wdata.alpha = CLEAR_ALPHA;
            depth_wdata       = DEPTH_FAR;
        end
        else
        begin
            mem_we      = put_we;
            mem_waddr   = addr_reg;
            color_wdata = color_reg;
            depth_wdata = depth_reg;
        end
    end

    dtps_ram #(
        .WIDTH (CWORD_W),
        .DEPTH (DEPTH)
    ) u_color_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (color_wdata),
        .re    (mem_re),
        .raddr (addr_in),
        .rdata (color_rdata)
    );

    dtps_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (DEPTH)
    ) u_depth_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (depth_wdata),
        .re    (mem_re),
        .raddr (addr_in),
        .rdata (depth_rdata)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_color_reg <= color_rdata;
            out_depth_reg <= depth_rdata;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, out_depth_reg, out_color_reg.alpha, out_color_reg.blue,
                       out_color_reg.green, out_color_reg.red};

endmodule

[design/dtps_ram.sv]
module dtps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

[tb/depth_tested_pixel_store_test.sv]
`timescale 1ns / 100ps

module depth_tested_pixel_store_test;
    import dtps_pkg::*;

    // the one command code the package leaves unnamed
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam int FRAME_W      = 256;
    localparam int FRAME_H      = 256;
    localparam int RANDOM_ITEMS = 1550;
    localparam int QUIET_ITEMS  = 200;
    localparam int BLOCK_ITEMS  = 50;
    localparam int SMALL_AREA   = 1024;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 2000000;

    // pixel read back by a get, red in the lowest bits as on m_tdata
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [ALPHA_W-1:0] alpha;
        logic [COL_W-1:0]   blue;
        logic [COL_W-1:0]   green;
        logic [COL_W-1:0]   red;
    } readback_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             s_tvalid;
    logic             s_tready;
    logic [1:0]       s_tuser;   // cmd
    // pos_x, pos_y, red_in, green_in, blue_in, alpha_in, depth_in
    logic [127:0]     s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    // red_out, green_out, blue_out, alpha_out, depth_out, zero pad
    logic [87:0]      m_tdata;

    // predicted frame contents and screen registers
    color_word_t      pixel_color [FRAME_W*FRAME_H];
    logic [DEPTH_W-1:0] pixel_depth [FRAME_W*FRAME_H];
    logic [CFG_W-1:0] screen_w_reg;
    logic [CFG_W-1:0] screen_h_reg;
    readback_t        readback_q[$];

    int errors;
    int items_accepted;
    int sender_gap_pct;
    int sink_stall_pct;
    int long_hold_req;
    bit quiet;
    bit sweep_open;

    depth_tested_pixel_store #(
        .MAX_WIDTH  (FRAME_W),
        .MAX_HEIGHT (FRAME_H)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycles);
        $display("depth_tested_pixel_store regression: fail");
        $finish;
    end

    // screen size in use: zero counts as one, large values saturate
    function automatic logic [CFG_W-1:0] screen_limit(input logic [CFG_W-1:0] raw, input int maxv);
        if (raw == '0)
            return 9'd1;
        if (raw > maxv)
            return CFG_W'(maxv);
        return raw;
    endfunction

    function automatic logic [7:0] coord_clamp(input logic [15:0] v, input logic [CFG_W-1:0] size);
        if (v[15])
            return 8'd0;
        if (v >= size)
            return 8'(size - 9'd1);
        return v[7:0];
    endfunction

    // frame address of a command, row major
    function automatic logic [15:0] pixel_index(input logic [15:0] px, input logic [15:0] py);
        return {coord_clamp(py, screen_limit(screen_h_reg, FRAME_H)),
                coord_clamp(px, screen_limit(screen_w_reg, FRAME_W))};
    endfunction

    function automatic logic [COL_W-1:0] saturate_intensity(input logic [15:0] v);
        if (v[15])
            return '0;
        if (v > 16'd4095)
            return COLOR_MAX;
        return v[COL_W-1:0];
    endfunction

    // update the predicted frame for one accepted command
    task automatic apply_pixel_command(input logic [1:0] cmd, input logic [15:0] px, py,
                                       input logic [15:0] r, g, b, a, input logic [31:0] z);
        int xx;
        int yy;
        logic [15:0] addr;
        addr = pixel_index(px, py);
        case (cmd)
            CMD_CLEAR:
            begin
                for (yy = 0; yy < screen_limit(screen_h_reg, FRAME_H); yy++)
                    for (xx = 0; xx < screen_limit(screen_w_reg, FRAME_W); xx++)
                    begin
                        pixel_color[yy*FRAME_W + xx] = '{alpha: CLEAR_ALPHA, blue: CLEAR_BLUE,
                                                         green: CLEAR_GREEN, red: CLEAR_RED};
                        pixel_depth[yy*FRAME_W + xx] = DEPTH_FAR;
                    end
                sweep_open = 1'b1;
            end
            CMD_PUT:
            begin
                if ($signed(z) < $signed(pixel_depth[addr]))
                begin
                    pixel_color[addr] = '{alpha: a, blue: saturate_intensity(b),
                                          green: saturate_intensity(g),
                                          red: saturate_intensity(r)};
                    pixel_depth[addr] = z;
                end
            end
            CMD_GET:
                readback_q.push_back('{depth: pixel_depth[addr], alpha: pixel_color[addr].alpha,
                                       blue: pixel_color[addr].blue,
                                       green: pixel_color[addr].green,
                                       red: pixel_color[addr].red});
            default: ;
        endcase
    endtask

    // offer one command until it is taken, then maybe leave a gap
    task automatic send_pixel_cmd(input logic [1:0] cmd, input logic [15:0] px, py,
                                  input logic [15:0] r, g, b, a, input logic [31:0] z);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {z, a, b, g, r, py, px};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_pixel_command(cmd, px, py, r, g, b, a, z);
        if (cmd != CMD_NONE)
            items_accepted++;
        if (!quiet && sender_gap_pct > 0 && $urandom_range(1, 100) <= sender_gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic put_pixel(input logic [15:0] px, py, r, g, b, a, input logic [31:0] z);
        send_pixel_cmd(CMD_PUT, px, py, r, g, b, a, z);
    endtask

    task automatic get_pixel(input logic [15:0] px, py);
        send_pixel_cmd(CMD_GET, px, py, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                       16'($urandom()), $urandom());
    endtask

    task automatic clear_frame();
        send_pixel_cmd(CMD_CLEAR, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                       16'($urandom()), 16'($urandom()), 16'($urandom()), $urandom());
    endtask

    // stop sending, wait for all reads, then let a running sweep finish
    task automatic wait_for_idle();
        int settle;
        s_tvalid <= 1'b0;
        while (readback_q.size() != 0)
            @(posedge clk);
        settle = 16;
        if (sweep_open)
            settle = screen_limit(screen_w_reg, FRAME_W) * screen_limit(screen_h_reg, FRAME_H)
                     + 16;
        sweep_open = 1'b0;
        repeat (settle) @(posedge clk);
    endtask

    // write both size registers on back to back cycles
    task automatic set_screen(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        screen_w_reg = w;
        cfg_index <= REG_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        screen_h_reg = h;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // result sink with random and requested stalls
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req > 0)
            begin
                hold_left = long_hold_req;
                long_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (!quiet && sink_stall_pct > 0 && $urandom_range(1, 100) <= sink_stall_pct)
            begin
                m_tready <= 1'b0;
                hold_left = $urandom_range(0, 11);
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // compare each read back pixel with the oldest prediction
    always @(posedge clk)
    begin
        readback_t got;
        readback_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[83:0];
            if (readback_q.size() == 0)
            begin
                $display("%0t: unexpected read back, expected none actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = readback_q.pop_front();
                check_field("red", 32'(want.red), 32'(got.red));
                check_field("green", 32'(want.green), 32'(got.green));
                check_field("blue", 32'(want.blue), 32'(got.blue));
                check_field("alpha", 32'(want.alpha), 32'(got.alpha));
                check_field("depth", want.depth, got.depth);
            end
        end
    end

    // first clear covers the whole frame, then read two opposite corners
    task automatic test_initial_clear();
        clear_frame();
        get_pixel(16'h8000, 16'h8000);
        get_pixel(16'h7FFF, 16'h7FFF);
    endtask

    // saturation of colors, alpha extremes, depth extremes, equal depth and coordinate clamping
    task automatic test_put_extremes();
        put_pixel(16'd5, 16'd7, 16'h8000, 16'h7FFF, 16'd4096, 16'h8000, 32'h8000_0000);
        get_pixel(16'd5, 16'd7);
        put_pixel(16'd5, 16'd7, 16'd100, 16'd100, 16'd100, 16'd100, 32'h8000_0000);
        put_pixel(16'd8, 16'd9, 16'd4095, 16'd0, 16'hFFFF, 16'h7FFF, 32'h7FFF_FFFF);
        get_pixel(16'd8, 16'd9);
        put_pixel(16'd8, 16'd9, 16'hFFFF, 16'd4095, 16'd0, 16'h7FFF, 32'h7FFF_FFFE);
        get_pixel(16'd8, 16'd9);
        put_pixel(16'd300, 16'hFFFB, 16'd1, 16'd2, 16'd3, 16'd4, 32'd0);
        get_pixel(16'd255, 16'd0);
    endtask

    // command code 3 must leave the frame alone
    task automatic test_unknown_cmd();
        send_pixel_cmd(CMD_NONE, 16'd255, 16'd0, 16'd7, 16'd7, 16'd7, 16'd7, 32'h8000_0000);
        get_pixel(16'd255, 16'd0);
    endtask

    // size extremes, clears of a partial screen, coordinate clamping
    task automatic test_screen_sizes();
        wait_for_idle();
        set_screen(9'd0, 9'd0);
        clear_frame();
        get_pixel(16'hFFFF, 16'd1000);
        wait_for_idle();
        set_screen(9'd511, 9'd511);
        get_pixel(16'd8, 16'd9);
        clear_frame();
        get_pixel(16'd255, 16'd255);
        wait_for_idle();
        set_screen(9'd1, 9'd256);
        put_pixel(16'd77, 16'd200, 16'd11, 16'd22, 16'd33, 16'd44, 32'd5);
        get_pixel(16'd0, 16'd200);
        wait_for_idle();
        set_screen(9'd256, 9'd1);
        get_pixel(16'hFFFD, 16'd99);
        wait_for_idle();
        set_screen(9'd3, 9'd2);
        clear_frame();
        get_pixel(16'd2, 16'd1);
        wait_for_idle();
    endtask

    // hold the sink off while gets keep coming, so the input stalls
    task automatic test_output_backpressure();
        int n;
        sender_gap_pct = 0;
        long_hold_req = LONG_HOLD;
        @(posedge clk);
        for (n = 0; n < 24; n++)
            get_pixel(16'($urandom_range(0, 3)), 16'($urandom_range(0, 2)));
        wait_for_idle();
    endtask

    function automatic logic [CFG_W-1:0] random_size();
        case ($urandom_range(0, 15))
            0:       return 9'd0;
            1:       return CFG_W'($urandom_range(257, 511));
            2:       return 9'd256;
            3:       return CFG_W'($urandom_range(33, 255));
            default: return CFG_W'($urandom_range(1, 32));
        endcase
    endfunction

    function automatic logic [15:0] random_coord(input logic [CFG_W-1:0] size);
        case ($urandom_range(0, 9))
            0:       return 16'($urandom());
            1:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            2:       return 16'(size - 9'd1);
            default: return 16'($urandom_range(0, size - 1));
        endcase
    endfunction

    function automatic logic [15:0] random_intensity();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom());
        return 16'($urandom_range(0, 4095));
    endfunction

    // depth near the stored one, so equal and off by one cases occur often
    function automatic logic [31:0] random_depth(input logic [15:0] px, input logic [15:0] py);
        logic [31:0] stored;
        stored = pixel_depth[pixel_index(px, py)];
        case ($urandom_range(0, 7))
            4:       return stored;
            5:       return stored - 32'd1;
            6:       return stored + 32'd1;
            7:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // blocks of put and get pairs under random screen sizes, with noise
    task automatic test_random_traffic();
        int first;
        int blk;
        int n;
        int op;
        logic [15:0] px;
        logic [15:0] py;
        logic [CFG_W-1:0] w_eff;
        logic [CFG_W-1:0] h_eff;
        first = items_accepted;
        blk = 0;
        while (items_accepted - first < RANDOM_ITEMS)
        begin
            wait_for_idle();
            quiet = (items_accepted - first >= RANDOM_ITEMS - QUIET_ITEMS);
            set_screen(random_size(), random_size());
            w_eff = screen_limit(screen_w_reg, FRAME_W);
            h_eff = screen_limit(screen_h_reg, FRAME_H);
            if (blk % 4 == 3)
            begin
                sender_gap_pct = 0;
                sink_stall_pct = 0;
            end
            else
            begin
                sender_gap_pct = $urandom_range(5, 40);
                sink_stall_pct = $urandom_range(5, 40);
            end
            if (w_eff * h_eff <= SMALL_AREA && $urandom_range(0, 1))
                clear_frame();
            for (n = 0; n < BLOCK_ITEMS; n++)
            begin
                px = random_coord(w_eff);
                py = random_coord(h_eff);
                op = $urandom_range(0, 99);
                if (op < 55)
                begin
                    put_pixel(px, py, random_intensity(), random_intensity(),
                              random_intensity(), 16'($urandom()), random_depth(px, py));
                    get_pixel(px, py);
                end
                else if (op < 75)
                    put_pixel(px, py, random_intensity(), random_intensity(),
                              random_intensity(), 16'($urandom()), random_depth(px, py));
                else if (op < 92)
                    get_pixel(px, py);
                else if (op < 95)
                    send_pixel_cmd(CMD_NONE, px, py, 16'($urandom()), 16'($urandom()),
                                   16'($urandom()), 16'($urandom()), $urandom());
                else if (w_eff * h_eff <= SMALL_AREA)
                    clear_frame();
                else
                    get_pixel(px, py);
            end
            blk++;
        end
    endtask

    // test sequence
    initial
    begin
        errors = 0;
        items_accepted = 0;
        sender_gap_pct = 20;
        sink_stall_pct = 20;
        long_hold_req = 0;
        quiet = 1'b0;
        sweep_open = 1'b0;
        screen_w_reg = SIZE_RESET;
        screen_h_reg = SIZE_RESET;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tuser   <= '0;
        s_tdata   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_initial_clear();
        test_put_extremes();
        test_unknown_cmd();
        test_screen_sizes();
        test_output_backpressure();
        test_random_traffic();

        wait_for_idle();
        if (readback_q.size() != 0)
        begin
            $display("%0t: %0d read backs never arrived", $time, readback_q.size());
            errors++;
        end
        if (errors == 0)
            $display("depth_tested_pixel_store regression: pass");
        else
            $display("depth_tested_pixel_store regression: fail");
        $finish;
    end

endmodule
